// ===== src/riffwav_pkg.sv =====
// ---------------------------------------------------------------------------
// riffwav_pkg
// Types and constants of the RIFF/WAVE PCM16 stream parser.
// ---------------------------------------------------------------------------
`default_nettype none

package riffwav_pkg;

    typedef enum logic [3:0] {
        PH_HEAD = 4'b0001,
        PH_CHDR = 4'b0010,
        PH_BODY = 4'b0100,
        PH_PAD  = 4'b1000
    } phase_t;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_NOTWAV  = 4'd1;
    localparam logic [3:0] ST_TRUNC   = 4'd2;
    localparam logic [3:0] ST_SHORT   = 4'd3;
    localparam logic [3:0] ST_PAD     = 4'd4;
    localparam logic [3:0] ST_MISSING = 4'd5;
    localparam logic [3:0] ST_UNSUP   = 4'd6;
    localparam logic [3:0] ST_ALIGN   = 4'd7;
    localparam logic [3:0] ST_LIMIT   = 4'd8;

    localparam logic [0:0] REG_MAX_FRAMES     = 1'b0;
    localparam logic [0:0] REG_MAX_DATA_BYTES = 1'b1;

    localparam logic [31:0] MAX_FRAMES_RESET     = 32'd16777216;
    localparam logic [31:0] MAX_DATA_BYTES_RESET = 32'd67108864;

    localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [3:0]  HEADER_LEN  = 4'd12;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        logic               chunk_first;
        logic [3:0]         status;
        logic [1:0]         channel_count;
        logic [31:0]        rate;
        logic               final_res;
    } result_t;

    function automatic logic [7:0] header_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h52;
            4'd1:    b = 8'h49;
            4'd2:    b = 8'h46;
            4'd3:    b = 8'h46;
            4'd8:    b = 8'h57;
            4'd9:    b = 8'h41;
            4'd10:   b = 8'h56;
            4'd11:   b = 8'h45;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== src/riff_wav_pcm16_parser_core.sv =====
// ---------------------------------------------------------------------------
// riff_wav_pcm16_parser_core
// Byte-serial RIFF/WAVE parser: header check, chunk walk, fmt capture,
// PCM16 sample output and one verdict per file.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while in_ready is high; in_ready drops while the result
//   queue holds two results and while the verdict is formed from the state registers.
// Output: a sample enters the result queue with the byte completing it; the end-of-file
//   byte sets pending_reg, and the verdict is queued from it.
// Reset: asynchronous, clears parse state and result queue, limits to defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module riff_wav_pcm16_parser_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         file_byte,
    input  wire logic               end_of_file,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    kind,
    output logic signed [15:0]      sample,
    output logic                    chunk_first,
    output logic [3:0]              status,
    output logic [1:0]              channel_count,
    output logic [31:0]             rate,
    output logic                    final_res,
    input  wire logic               cfg_write_en,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    riffwav_pkg::phase_t  phase_reg, phase_next;
    logic [31:0]          counter_reg, counter_next;
    logic [31:0]          tag_reg, tag_next;
    logic [31:0]          len_reg, len_next;
    logic [127:0]         fmt_reg, fmt_next;
    logic [31:0]          data_len_reg, data_len_next;
    logic                 fmt_seen_reg, fmt_seen_next;
    logic                 data_seen_reg, data_seen_next;
    logic                 first_reg, first_next;
    logic [7:0]           low_reg, low_next;
    logic [3:0]           err_reg, err_next;
    logic                 pending_reg;
    logic [31:0]          max_frames_reg;
    logic [31:0]          max_data_bytes_reg;

    riffwav_pkg::result_t q_reg [3];
    riffwav_pkg::result_t q_next [3];
    logic [1:0]           count_reg, count_next;

    logic                 accept;
    logic                 push;
    logic                 pop;
    riffwav_pkg::result_t push_data;
    riffwav_pkg::result_t sample_res;
    riffwav_pkg::result_t verdict_res;
    logic                 sample_push;
    logic [31:0]          idx_inc;
    logic [31:0]          full_len;
    logic [1:0]           base;

    logic [15:0]          f_format;
    logic [15:0]          f_channels;
    logic [31:0]          f_rate;
    logic [15:0]          f_align;
    logic [15:0]          f_bits;
    logic [31:0]          frames;
    logic                 misaligned;
    logic [3:0]           v_status;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (count_reg <= 2'd1) && !pending_reg;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;

    assign idx_inc  = counter_reg + 32'd1;
    assign full_len = {file_byte, len_reg[23:0]};

    always_comb
    begin
        phase_next     = phase_reg;
        counter_next   = counter_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        fmt_next       = fmt_reg;
        data_len_next  = data_len_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        first_next     = first_reg;
        low_next       = low_reg;
        err_next       = err_reg;
        sample_push    = 1'b0;

        if (pending_reg)
        begin
            phase_next     = riffwav_pkg::PH_HEAD;
            counter_next   = 32'd0;
            tag_next       = 32'd0;
            len_next       = 32'd0;
            fmt_next       = 128'd0;
            data_len_next  = 32'd0;
            fmt_seen_next  = 1'b0;
            data_seen_next = 1'b0;
            first_next     = 1'b0;
            low_next       = 8'd0;
            err_next       = riffwav_pkg::ST_OK;
        end
        else if (accept && err_reg == riffwav_pkg::ST_OK)
        begin
            unique case (phase_reg)
                riffwav_pkg::PH_HEAD:
                begin
                    if ((counter_reg[3:0] < 4'd4 || counter_reg[3:0] >= 4'd8) &&
                        riffwav_pkg::header_byte(counter_reg[3:0]) != file_byte)
                    begin
                        err_next = riffwav_pkg::ST_NOTWAV;
                    end
                    counter_next = idx_inc;
                    if (idx_inc[3:0] >= riffwav_pkg::HEADER_LEN)
                    begin
                        phase_next   = riffwav_pkg::PH_CHDR;
                        counter_next = 32'd0;
                    end
                end
                riffwav_pkg::PH_CHDR:
                begin
                    if (counter_reg[2:0] == 3'd0)
                    begin
                        tag_next = {24'd0, file_byte};
                        len_next = 32'd0;
                    end
                    else if (!counter_reg[2])
                    begin
                        tag_next[{counter_reg[1:0], 3'b000} +: 8] = file_byte;
                    end
                    else
                    begin
                        len_next[{counter_reg[1:0], 3'b000} +: 8] = file_byte;
                    end
                    counter_next = {29'd0, counter_reg[2:0]} + 32'd1;
                    if (counter_reg[2:0] == 3'd7)
                    begin
                        counter_next = 32'd0;
                        phase_next   = riffwav_pkg::PH_BODY;
                        if (tag_reg == riffwav_pkg::TAG_FMT &&
                            full_len >= riffwav_pkg::FMT_MIN_LEN)
                        begin
                            fmt_seen_next = 1'b1;
                        end
                        if (tag_reg == riffwav_pkg::TAG_DATA)
                        begin
                            data_seen_next = 1'b1;
                            first_next     = 1'b1;
                            data_len_next  = full_len;
                        end
                        if (full_len == 32'd0)
                        begin
                            if (tag_reg == riffwav_pkg::TAG_FMT)
                            begin
                                err_next = riffwav_pkg::ST_SHORT;
                            end
                            else
                            begin
                                phase_next = riffwav_pkg::PH_CHDR;
                            end
                        end
                    end
                end
                riffwav_pkg::PH_BODY:
                begin
                    if (tag_reg == riffwav_pkg::TAG_FMT &&
                        len_reg >= riffwav_pkg::FMT_MIN_LEN && counter_reg < 32'd16)
                    begin
                        fmt_next[{counter_reg[3:0], 3'b000} +: 8] = file_byte;
                    end
                    if (tag_reg == riffwav_pkg::TAG_DATA)
                    begin
                        if (!counter_reg[0])
                        begin
                            low_next = file_byte;
                        end
                        else
                        begin
                            sample_push = 1'b1;
                            first_next  = 1'b0;
                        end
                    end
                    counter_next = idx_inc;
                    if (idx_inc >= len_reg)
                    begin
                        counter_next = 32'd0;
                        if (tag_reg == riffwav_pkg::TAG_FMT &&
                            len_reg < riffwav_pkg::FMT_MIN_LEN)
                        begin
                            err_next = riffwav_pkg::ST_SHORT;
                        end
                        else if (len_reg[0])
                        begin
                            phase_next = riffwav_pkg::PH_PAD;
                        end
                        else
                        begin
                            phase_next = riffwav_pkg::PH_CHDR;
                        end
                    end
                end
                riffwav_pkg::PH_PAD:
                begin
                    phase_next   = riffwav_pkg::PH_CHDR;
                    counter_next = 32'd0;
                end
                default:
                begin
                    phase_next   = riffwav_pkg::PH_HEAD;
                    counter_next = 32'd0;
                end
            endcase
        end
    end

    assign f_format   = fmt_reg[15:0];
    assign f_channels = fmt_reg[31:16];
    assign f_rate     = fmt_reg[63:32];
    assign f_align    = fmt_reg[111:96];
    assign f_bits     = fmt_reg[127:112];

    assign frames     = f_channels[1] ? {2'd0, data_len_reg[31:2]}
                                      : {1'b0, data_len_reg[31:1]};
    assign misaligned = f_channels[1] ? (data_len_reg[1:0] != 2'd0) : data_len_reg[0];

    always_comb
    begin
        if (err_reg != riffwav_pkg::ST_OK)
        begin
            v_status = err_reg;
        end
        else if (phase_reg == riffwav_pkg::PH_HEAD)
        begin
            v_status = riffwav_pkg::ST_NOTWAV;
        end
        else if (phase_reg == riffwav_pkg::PH_BODY)
        begin
            v_status = riffwav_pkg::ST_TRUNC;
        end
        else if (phase_reg == riffwav_pkg::PH_PAD)
        begin
            v_status = riffwav_pkg::ST_PAD;
        end
        else if (!(fmt_seen_reg && data_seen_reg))
        begin
            v_status = riffwav_pkg::ST_MISSING;
        end
        else if (f_format != 16'd1 || f_bits != 16'd16 ||
                 (f_channels != 16'd1 && f_channels != 16'd2) || f_rate == 32'd0)
        begin
            v_status = riffwav_pkg::ST_UNSUP;
        end
        else if (f_align != {f_channels[14:0], 1'b0} || misaligned)
        begin
            v_status = riffwav_pkg::ST_ALIGN;
        end
        else if (frames > max_frames_reg || data_len_reg > max_data_bytes_reg)
        begin
            v_status = riffwav_pkg::ST_LIMIT;
        end
        else
        begin
            v_status = riffwav_pkg::ST_OK;
        end
    end

    always_comb
    begin
        sample_res               = '0;
        sample_res.sample        = {file_byte, low_reg};
        sample_res.chunk_first   = first_reg;

        verdict_res              = '0;
        verdict_res.kind         = 1'b1;
        verdict_res.status       = v_status;
        verdict_res.final_res    = 1'b1;
        if (v_status == riffwav_pkg::ST_OK)
        begin
            verdict_res.channel_count = f_channels[1:0];
            verdict_res.rate          = f_rate;
        end
    end

    assign push      = pending_reg || sample_push;
    assign push_data = pending_reg ? verdict_res : sample_res;
    assign base      = count_reg - {1'b0, pop};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pop && i < 2)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push && base == 2'(i))
            begin
                q_next[i] = push_data;
            end
        end
        count_next = base + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= riffwav_pkg::PH_HEAD;
            counter_reg        <= 32'd0;
            tag_reg            <= 32'd0;
            len_reg            <= 32'd0;
            fmt_reg            <= 128'd0;
            data_len_reg       <= 32'd0;
            fmt_seen_reg       <= 1'b0;
            data_seen_reg      <= 1'b0;
            first_reg          <= 1'b0;
            low_reg            <= 8'd0;
            err_reg            <= riffwav_pkg::ST_OK;
            pending_reg        <= 1'b0;
            count_reg          <= 2'd0;
            max_frames_reg     <= riffwav_pkg::MAX_FRAMES_RESET;
            max_data_bytes_reg <= riffwav_pkg::MAX_DATA_BYTES_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            counter_reg   <= counter_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            fmt_reg       <= fmt_next;
            data_len_reg  <= data_len_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            first_reg     <= first_next;
            low_reg       <= low_next;
            err_reg       <= err_next;
            pending_reg   <= accept && end_of_file;
            count_reg     <= count_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    riffwav_pkg::REG_MAX_FRAMES:     max_frames_reg     <= cfg_data;
                    riffwav_pkg::REG_MAX_DATA_BYTES: max_data_bytes_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    assign kind          = q_reg[0].kind;
    assign sample        = q_reg[0].sample;
    assign chunk_first   = q_reg[0].chunk_first;
    assign status        = q_reg[0].status;
    assign channel_count = q_reg[0].channel_count;
    assign rate          = q_reg[0].rate;
    assign final_res     = q_reg[0].final_res;

    a_eof_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_of_file) |=> pending_reg)
        else $error("verdict not scheduled after end of file");

    a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |=> (phase_reg == riffwav_pkg::PH_HEAD &&
                         err_reg == riffwav_pkg::ST_OK && counter_reg == 32'd0))
        else $error("parse state not cleared after verdict");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && final_res && status != riffwav_pkg::ST_OK) |->
            (channel_count == 2'd0 && rate == 32'd0))
        else $error("failing verdict carries format data");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg || sample_push) |-> (base != 2'd3))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== tb/riffwav_checker.sv =====
// ---------------------------------------------------------------------------
// riffwav_checker
// Scoreboard for the RIFF/WAVE PCM16 parser: byte-level model and comparison.
// Watches the byte and result channels and the limit write port. For every
// accepted byte it advances its own copy of the parse state and queues the
// samples and verdict that the byte causes. It compares each accepted result
// field by field against the oldest queued one. It hands the mismatch count,
// the number of results still outstanding and the compared totals to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module riffwav_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [7:0]         file_byte,
    input  wire logic               end_of_file,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic               kind,
    input  wire logic signed [15:0] sample,
    input  wire logic               chunk_first,
    input  wire logic [3:0]         status,
    input  wire logic [1:0]         channel_count,
    input  wire logic [31:0]        rate,
    input  wire logic               final_res,
    input  wire logic               cfg_write_en,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      fail_count,
    output int                      outstanding,
    output int                      samples_checked,
    output int                      verdicts_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [95:0] RIFF_MAGIC = {"RIFF", 32'h0, "WAVE"};
    localparam int          MAX_PRINTED = 100;

    riffwav_pkg::result_t expected_results[$];
    logic [31:0]          lim_frames;
    logic [31:0]          lim_data_bytes;
    riffwav_pkg::phase_t  phase;
    logic [31:0]          pos;
    logic [31:0]          tag;
    logic [31:0]          clen;
    logic [31:0]          dlen;
    logic [63:0]          fmt_lo;
    logic [63:0]          fmt_hi;
    logic                 have_fmt;
    logic                 have_data;
    logic                 mark_first;
    logic [7:0]           low_hold;
    logic [3:0]           fault;
    int                   nreports;
    int                   nsamples;
    int                   nverdicts;

    task automatic clear_stream();
        phase      = riffwav_pkg::PH_HEAD;
        pos        = '0;
        tag        = '0;
        clen       = '0;
        dlen       = '0;
        fmt_lo     = '0;
        fmt_hi     = '0;
        have_fmt   = 1'b0;
        have_data  = 1'b0;
        mark_first = 1'b0;
        low_hold   = '0;
        fault      = riffwav_pkg::ST_OK;
    endtask

    task automatic close_body();
        pos = '0;
        if (tag == riffwav_pkg::TAG_FMT && clen < riffwav_pkg::FMT_MIN_LEN)
            fault = riffwav_pkg::ST_SHORT;
        else if (clen[0])
            phase = riffwav_pkg::PH_PAD;
        else
            phase = riffwav_pkg::PH_CHDR;
    endtask

    function automatic logic [3:0] judge_file(output logic [1:0] ch, output logic [31:0] hz);
        logic [15:0] fmt_code;
        logic [15:0] chans;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] srate;
        ch = '0;
        hz = '0;
        if (fault != riffwav_pkg::ST_OK)
            return fault;
        if (phase == riffwav_pkg::PH_HEAD)
            return riffwav_pkg::ST_NOTWAV;
        if (phase == riffwav_pkg::PH_BODY)
            return riffwav_pkg::ST_TRUNC;
        if (phase == riffwav_pkg::PH_PAD)
            return riffwav_pkg::ST_PAD;
        if (!(have_fmt && have_data))
            return riffwav_pkg::ST_MISSING;
        fmt_code = fmt_lo[15:0];
        chans    = fmt_lo[31:16];
        srate    = fmt_lo[63:32];
        align    = fmt_hi[47:32];
        bits     = fmt_hi[63:48];
        if (fmt_code != 16'd1 || bits != 16'd16 || (chans != 16'd1 && chans != 16'd2)
            || srate == 32'd0)
            return riffwav_pkg::ST_UNSUP;
        if (align != chans * 16'd2)
            return riffwav_pkg::ST_ALIGN;
        if ((dlen % {16'd0, align}) != 32'd0)
            return riffwav_pkg::ST_ALIGN;
        if (dlen / {16'd0, align} > lim_frames || dlen > lim_data_bytes)
            return riffwav_pkg::ST_LIMIT;
        ch = chans[1:0];
        hz = srate;
        return riffwav_pkg::ST_OK;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic eof);
        logic [31:0]          idx;
        riffwav_pkg::result_t r;
        logic [1:0]           ch;
        logic [31:0]          hz;
        idx = pos;
        if (fault == riffwav_pkg::ST_OK) begin
            case (phase)
                riffwav_pkg::PH_HEAD: begin
                    if ((idx < 4 || idx >= 8) && RIFF_MAGIC[95 - 8 * idx -: 8] != b)
                        fault = riffwav_pkg::ST_NOTWAV;
                    pos = idx + 1;
                    if (pos >= riffwav_pkg::HEADER_LEN) begin
                        phase = riffwav_pkg::PH_CHDR;
                        pos   = '0;
                    end
                end
                riffwav_pkg::PH_CHDR: begin
                    idx = idx & 32'd7;
                    if (idx == 0) begin
                        tag  = '0;
                        clen = '0;
                    end
                    if (idx < 4)
                        tag = tag | (32'(b) << (8 * idx));
                    else
                        clen = clen | (32'(b) << (8 * (idx - 4)));
                    pos = idx + 1;
                    if (pos == 8) begin
                        pos = '0;
                        if (tag == riffwav_pkg::TAG_FMT && clen >= riffwav_pkg::FMT_MIN_LEN)
                            have_fmt = 1'b1;
                        if (tag == riffwav_pkg::TAG_DATA) begin
                            have_data  = 1'b1;
                            mark_first = 1'b1;
                            dlen       = clen;
                        end
                        phase = riffwav_pkg::PH_BODY;
                        if (clen == 0)
                            close_body();
                    end
                end
                riffwav_pkg::PH_BODY: begin
                    if (tag == riffwav_pkg::TAG_FMT && clen >= riffwav_pkg::FMT_MIN_LEN
                        && idx < 16) begin
                        if (idx < 8)
                            fmt_lo[8 * idx +: 8] = b;
                        else
                            fmt_hi[8 * (idx - 8) +: 8] = b;
                    end
                    if (tag == riffwav_pkg::TAG_DATA) begin
                        if (!idx[0]) begin
                            low_hold = b;
                        end
                        else begin
                            r             = '0;
                            r.sample      = {b, low_hold};
                            r.chunk_first = mark_first;
                            expected_results.push_back(r);
                            mark_first = 1'b0;
                        end
                    end
                    pos = idx + 1;
                    if (pos >= clen)
                        close_body();
                end
                default: begin
                    phase = riffwav_pkg::PH_CHDR;
                    pos   = '0;
                end
            endcase
        end
        if (eof) begin
            r               = '0;
            r.kind          = 1'b1;
            r.status        = judge_file(ch, hz);
            r.channel_count = ch;
            r.rate          = hz;
            r.final_res     = 1'b1;
            expected_results.push_back(r);
            clear_stream();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        nreports++;
        if (nreports <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result();
        riffwav_pkg::result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", {31'd0, kind}, 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (kind != want.kind)
            report_mismatch("kind", {31'd0, kind}, {31'd0, want.kind});
        if (sample != want.sample)
            report_mismatch("sample", {16'd0, sample}, {16'd0, want.sample});
        if (chunk_first != want.chunk_first)
            report_mismatch("chunk_first", {31'd0, chunk_first}, {31'd0, want.chunk_first});
        if (status != want.status)
            report_mismatch("status", {28'd0, status}, {28'd0, want.status});
        if (channel_count != want.channel_count)
            report_mismatch("channel_count", {30'd0, channel_count},
                            {30'd0, want.channel_count});
        if (rate != want.rate)
            report_mismatch("rate", rate, want.rate);
        if (final_res != want.final_res)
            report_mismatch("final_res", {31'd0, final_res}, {31'd0, want.final_res});
        if (want.kind)
            nverdicts++;
        else
            nsamples++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_results.delete();
            clear_stream();
            lim_frames       = riffwav_pkg::MAX_FRAMES_RESET;
            lim_data_bytes   = riffwav_pkg::MAX_DATA_BYTES_RESET;
            nreports         = 0;
            nsamples         = 0;
            nverdicts        = 0;
            fail_count       <= 0;
            outstanding      <= 0;
            samples_checked  <= 0;
            verdicts_checked <= 0;
        end
        else begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_byte(file_byte, end_of_file);
            if (cfg_write_en) begin
                case (cfg_index)
                    riffwav_pkg::REG_MAX_FRAMES:     lim_frames     = cfg_data;
                    riffwav_pkg::REG_MAX_DATA_BYTES: lim_data_bytes = cfg_data;
                    default:                         ;
                endcase
            end
            fail_count       <= nreports;
            outstanding      <= expected_results.size();
            samples_checked  <= nsamples;
            verdicts_checked <= nverdicts;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for riff_wav_pcm16_parser_core.
// Streams whole WAV files one byte per transaction: a few directed header
// cases, then random files built from well-formed chunk sequences with
// corrupted headers, odd and short chunks, trailing bytes, truncation and
// noise mixed in. Limits are rewritten between phases while the parser is
// idle. Both channels idle at random, apart from one calm stretch.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEM_TARGET = 1650;
    localparam int          PHASE_ITEMS = 330;
    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic [7:0]         file_byte     = 8'd0;
    logic               end_of_file   = 1'b0;
    logic               out_ready     = 1'b0;
    logic               cfg_write_en  = 1'b0;
    logic [0:0]         cfg_index     = riffwav_pkg::REG_MAX_FRAMES;
    logic [31:0]        cfg_data      = 32'd0;
    logic               in_ready;
    logic               out_valid;
    logic               kind;
    logic signed [15:0] sample;
    logic               chunk_first;
    logic [3:0]         status;
    logic [1:0]         channel_count;
    logic [31:0]        rate;
    logic               final_res;

    int                 fail_count;
    int                 outstanding;
    int                 samples_checked;
    int                 verdicts_checked;
    int                 cycles      = 0;
    int                 bytes_sent  = 0;
    int                 files_sent  = 0;
    logic               calm        = 1'b0;
    bit                 cut_off;
    logic [15:0]        cur_align;
    logic [7:0]         wav_bytes[$];

    riff_wav_pcm16_parser_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .file_byte     (file_byte),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .sample        (sample),
        .chunk_first   (chunk_first),
        .status        (status),
        .channel_count (channel_count),
        .rate          (rate),
        .final_res     (final_res),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    riffwav_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .file_byte        (file_byte),
        .end_of_file      (end_of_file),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .sample           (sample),
        .chunk_first      (chunk_first),
        .status           (status),
        .channel_count    (channel_count),
        .rate             (rate),
        .final_res        (final_res),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .samples_checked  (samples_checked),
        .verdicts_checked (verdicts_checked)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("FAIL");
            $finish;
        end
    end

    task automatic put_le16(input logic [15:0] v);
        wav_bytes.push_back(v[7:0]);
        wav_bytes.push_back(v[15:8]);
    endtask

    task automatic put_le32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            wav_bytes.push_back(v[8 * i +: 8]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) wav_bytes.push_back(8'($urandom()));
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic put_fmt();
        int          sel;
        logic [31:0] len;
        logic [31:0] hz;
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] blk;
        logic [15:0] bits;
        sel = $urandom_range(0, 11);
        if (sel == 0)
        begin
            len = $urandom_range(0, 15);
            put_le32(riffwav_pkg::TAG_FMT);
            put_le32(len);
            put_noise(len);
            if (len[0])
                put_noise(1);
            return;
        end
        len   = (sel == 1) ? 32'd18 : (sel == 2) ? 32'd17 : 32'd16;
        code  = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'd1;
        chans = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3))
                                            : 16'($urandom_range(1, 2));
        blk   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 8)) : chans * 16'd2;
        bits  = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'd16;
        hz    = ($urandom_range(0, 11) == 0) ? 32'd0 : $urandom();
        put_le32(riffwav_pkg::TAG_FMT);
        put_le32(len);
        put_le16(code);
        put_le16(chans);
        put_le32(hz);
        put_le32(hz * blk);
        put_le16(blk);
        put_le16(bits);
        put_noise(len - 16);
        if (len[0])
            put_noise(1);
        cur_align = (blk == 16'd0) ? 16'd2 : blk;
    endtask

    task automatic put_data();
        logic [31:0] len;
        len = $urandom_range(0, 10) * cur_align;
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(0, 15);
        put_le32(riffwav_pkg::TAG_DATA);
        put_le32(len);
        for (int i = 0; i + 1 < len; i += 2)
            put_le16(pick_sample());
        if (len[0])
            put_noise(2);
    endtask

    task automatic put_junk();
        logic [31:0] len;
        put_le32($urandom());
        if ($urandom_range(0, 9) == 0)
        begin
            // huge body: the file stops inside it
            put_le32($urandom() | 32'h100);
            put_noise($urandom_range(0, 6));
            cut_off = 1'b1;
            return;
        end
        len = $urandom_range(0, 9);
        put_le32(len);
        put_noise(len);
        if (len[0])
            put_noise(1);
    endtask

    task automatic put_chunk(input int sel);
        if (cut_off)
            return;
        case (sel)
            0:       put_fmt();
            1:       put_data();
            default: put_junk();
        endcase
    endtask

    task automatic build_wav();
        int pick;
        int cut;
        wav_bytes.delete();
        cut_off   = 1'b0;
        cur_align = 16'd2;
        if ($urandom_range(0, 24) == 0)
        begin
            put_noise($urandom_range(1, 16));
            return;
        end
        put_le32(TAG_RIFF);
        put_le32($urandom());
        put_le32(TAG_WAVE);
        if ($urandom_range(0, 11) == 0)
        begin
            pick = $urandom_range(0, 7);
            if (pick >= 4)
                pick += 4;
            wav_bytes[pick] = wav_bytes[pick] ^ 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 5) == 0)
                put_chunk(2);
            put_chunk(0);
            if ($urandom_range(0, 5) == 0)
                put_chunk(2);
            put_chunk(1);
            if ($urandom_range(0, 7) == 0)
                put_chunk($urandom_range(0, 2));
        end
        else
        begin
            repeat ($urandom_range(1, 4)) put_chunk($urandom_range(0, 2));
        end
        if (!cut_off && $urandom_range(0, 6) == 0)
            put_noise($urandom_range(1, 7));
        if ($urandom_range(0, 7) == 0 && wav_bytes.size() > 1)
        begin
            cut = $urandom_range(1, wav_bytes.size() - 1);
            while (wav_bytes.size() > cut)
                void'(wav_bytes.pop_back());
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        file_byte   <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        calm = (bytes_sent >= 600 && bytes_sent < 900);
    endtask

    task automatic send_file();
        for (int i = 0; i < wav_bytes.size(); i++)
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(input logic [31:0] frames, input logic [31:0] data_bytes);
        cfg_write_en <= 1'b1;
        cfg_index    <= riffwav_pkg::REG_MAX_FRAMES;
        cfg_data     <= frames;
        @(posedge clk);
        cfg_index    <= riffwav_pkg::REG_MAX_DATA_BYTES;
        cfg_data     <= data_bytes;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int phase_no;
        int phase_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bad first byte, end inside the header, header alone
        wav_bytes.delete();
        wav_bytes.push_back(8'h58);
        send_file();
        wav_bytes.delete();
        put_le32(TAG_RIFF);
        send_file();
        wav_bytes.delete();
        put_le32(TAG_RIFF);
        put_le32(32'hFFFF_FFFF);
        put_le32(TAG_WAVE);
        send_file();

        phase_no = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (phase_no > 0)
            begin
                drain();
                case (phase_no % 5)
                    1:       write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    2:       write_limits(32'd0, 32'd0);
                    3:       write_limits($urandom_range(0, 8), $urandom_range(0, 30));
                    4:       write_limits($urandom(), $urandom());
                    default: write_limits(riffwav_pkg::MAX_FRAMES_RESET,
                                          riffwav_pkg::MAX_DATA_BYTES_RESET);
                endcase
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS && bytes_sent < ITEM_TARGET)
            begin
                build_wav();
                send_file();
            end
            phase_no++;
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d files in %0d bytes over %0d limit settings", files_sent,
                 bytes_sent, phase_no);
        $display("Compared %0d samples and %0d verdicts, %0d mismatches", samples_checked,
                 verdicts_checked, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
